// ===== hdl/msseq_pkg.sv =====
// Package for the motor start-up sequencer: widths, register indexes, phase codes,
// and the structs passed between the sequencer modules.
// No dependencies; every other file in hdl/ imports this package.
package msseq_pkg;

    // Width of the phase down-counter.
    localparam int TICK_WIDTH = 16;

    // Width of a configured duration register.
    localparam int DUR_WIDTH = 16;

    // Width of the configuration register index.
    localparam int CFG_INDEX_WIDTH = 8;

    // Reset value of every duration register.
    localparam logic [DUR_WIDTH-1:0] DUR_RESET = 16'd1000;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SETTLE_TICKS    = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CALIBRATE_TICKS = 8'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ALIGN_TICKS     = 8'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OPEN_LOOP_TICKS = 8'd3;

    typedef logic [TICK_WIDTH-1:0] tick_t;
    typedef logic [DUR_WIDTH-1:0]  dur_t;

    // Sequencer phases, encoded as reported on the result channel.
    typedef enum logic [3:0] {
        PH_POWER_ON  = 4'd0,
        PH_SETTLE    = 4'd1,
        PH_CALIBRATE = 4'd2,
        PH_IDLE      = 4'd3,
        PH_ALIGN     = 4'd4,
        PH_OPEN_LOOP = 4'd5,
        PH_CLOSED    = 4'd6,
        PH_SHUTDOWN  = 4'd7,
        PH_FAULT     = 4'd8
    } phase_t;

    // Configured phase durations.
    typedef struct packed {
        dur_t settle;
        dur_t calibrate;
        dur_t align;
        dur_t open_loop;
    } durations_t;

    // One control-period tick.
    typedef struct packed {
        logic start_request;
        logic current_at_target;
        logic force_fault;
    } tick_item_t;

    // Sequencer status after one tick.
    typedef struct packed {
        phase_t phase;
        logic   offset_calibration_on;
        logic   calibration_done;
        logic   begin_open_loop;
        logic   begin_closed_loop;
    } result_t;

    // Fits a duration to the counter width (zero-extend or truncate).
    function automatic tick_t load_duration(input dur_t dur);
        logic [TICK_WIDTH+DUR_WIDTH-1:0] ext;
        ext = {{TICK_WIDTH{1'b0}}, dur};
        return ext[TICK_WIDTH-1:0];
    endfunction

endpackage

// ===== hdl/msseq_if.sv =====
// Channel interfaces of the motor start-up sequencer: tick input, status output
// and configuration write. Depends on msseq_pkg for widths.

// Tick channel: one transaction per control period.
interface msseq_tick_if;
    logic valid;
    logic ready;
    logic start_request;
    logic current_at_target;
    logic force_fault;

    modport source (output valid, start_request, current_at_target, force_fault,
                    input ready);
    modport sink   (input valid, start_request, current_at_target, force_fault,
                    output ready);
endinterface

// Status channel: one transaction per accepted tick.
interface msseq_status_if;
    logic       valid;
    logic       ready;
    logic [3:0] phase;
    logic       offset_calibration_on;
    logic       calibration_done;
    logic       begin_open_loop;
    logic       begin_closed_loop;

    modport source (output valid, phase, offset_calibration_on, calibration_done,
                    begin_open_loop, begin_closed_loop, input ready);
    modport sink   (input valid, phase, offset_calibration_on, calibration_done,
                    begin_open_loop, begin_closed_loop, output ready);
endinterface

// Configuration write channel.
interface msseq_cfg_if;
    import msseq_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [DUR_WIDTH-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/msseq_cfg_regs.sv =====
// Duration registers of the motor start-up sequencer, written over the
// configuration channel. Depends on msseq_pkg and msseq_if.
module msseq_cfg_regs
    import msseq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    msseq_cfg_if.sink   cfg,
    output durations_t  durations
);

    durations_t dur_reg;
    durations_t dur_next;

    // Writes are always taken; the user must keep the block idle whenever configuration changes (not enforced here).
    assign cfg.ready = 1'b1;

    // Decode the register index of a write transaction.
    always_comb
    begin
        dur_next = dur_reg;
        if (cfg.valid)
        begin
            if (cfg.index == REG_SETTLE_TICKS)
            begin
                dur_next.settle = cfg.data;
            end
            if (cfg.index == REG_CALIBRATE_TICKS)
            begin
                dur_next.calibrate = cfg.data;
            end
            if (cfg.index == REG_ALIGN_TICKS)
            begin
                dur_next.align = cfg.data;
            end
            if (cfg.index == REG_OPEN_LOOP_TICKS)
            begin
                dur_next.open_loop = cfg.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_reg <= '{settle: DUR_RESET, calibrate: DUR_RESET,
                         align: DUR_RESET, open_loop: DUR_RESET};
        end
        else
        begin
            dur_reg <= dur_next;
        end
    end

    assign durations = dur_reg;

endmodule

// ===== hdl/msseq_fsm.sv =====
// Phase state machine of the motor start-up sequencer: phase, down-counter and
// calibration flags, advanced once per tick. Depends on msseq_pkg.
module msseq_fsm
    import msseq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  tick_item_t item,
    input  durations_t durations,
    output result_t    result
);

    phase_t phase_reg;
    phase_t phase_next;
    tick_t  ticks_reg;
    tick_t  ticks_next;
    logic   offset_reg;
    logic   offset_next;
    logic   cal_reg;
    logic   cal_next;
    logic   expired;
    logic   pulse_open;
    logic   pulse_closed;

    // The timer has expired when the counter already stands at zero.
    assign expired = (ticks_reg == '0);

    // Next phase, counter and flags.
    always_comb
    begin
        phase_next  = phase_reg;
        ticks_next  = ticks_reg;
        offset_next = offset_reg;
        cal_next    = cal_reg;
        if (item.force_fault)
        begin
            phase_next = PH_FAULT;
        end
        else
        begin
            unique case (phase_reg)
                PH_POWER_ON:
                begin
                    ticks_next = load_duration(durations.settle);
                    phase_next = PH_SETTLE;
                end
                PH_SETTLE:
                begin
                    if (expired)
                    begin
                        ticks_next  = load_duration(durations.calibrate);
                        phase_next  = PH_CALIBRATE;
                        offset_next = 1'b1;
                    end
                    else
                    begin
                        ticks_next = ticks_reg - tick_t'(1);
                    end
                end
                PH_CALIBRATE:
                begin
                    if (expired)
                    begin
                        offset_next = 1'b0;
                        cal_next    = 1'b1;
                        phase_next  = PH_IDLE;
                    end
                    else
                    begin
                        ticks_next = ticks_reg - tick_t'(1);
                    end
                end
                PH_IDLE:
                begin
                    if (item.start_request)
                    begin
                        ticks_next = load_duration(durations.align);
                        phase_next = PH_ALIGN;
                    end
                end
                PH_ALIGN:
                begin
                    if (expired)
                    begin
                        ticks_next = load_duration(durations.open_loop);
                        phase_next = PH_OPEN_LOOP;
                    end
                    else
                    begin
                        ticks_next = ticks_reg - tick_t'(1);
                    end
                end
                PH_OPEN_LOOP:
                begin
                    // The counter runs down whatever the current does and rests at zero.
                    if (!expired)
                    begin
                        ticks_next = ticks_reg - tick_t'(1);
                    end
                    else if (item.current_at_target)
                    begin
                        phase_next = PH_CLOSED;
                    end
                end
                PH_CLOSED:
                begin
                    if (!item.start_request)
                    begin
                        phase_next = PH_SHUTDOWN;
                    end
                end
                default:
                begin
                    // Shutdown and fault both return to idle.
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // One-tick pulses on entry to open loop and closed loop.
    always_comb
    begin
        pulse_open   = 1'b0;
        pulse_closed = 1'b0;
        if (!item.force_fault && expired)
        begin
            pulse_open   = (phase_reg == PH_ALIGN);
            pulse_closed = (phase_reg == PH_OPEN_LOOP) && item.current_at_target;
        end
    end

    // Status reports the state after the tick.
    assign result = '{phase: phase_next, offset_calibration_on: offset_next,
                      calibration_done: cal_next, begin_open_loop: pulse_open,
                      begin_closed_loop: pulse_closed};

    // State advances only when a tick moves into the status register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_POWER_ON;
            ticks_reg  <= '0;
            offset_reg <= 1'b0;
            cal_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            ticks_reg  <= ticks_next;
            offset_reg <= offset_next;
            cal_reg    <= cal_next;
        end
    end

    // Calibration running and calibration finished never hold together.
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(offset_reg && cal_reg))
        else $error("offset calibration active after calibration done");

    // An open-loop start pulse leaves the sequencer in open loop.
    a_open_pulse_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (step && pulse_open) |=> (phase_reg == PH_OPEN_LOOP))
        else $error("open-loop pulse without entering open loop");

    // A closed-loop start pulse only follows an expired open-loop timer.
    a_closed_pulse_timer: assert property (@(posedge clk) disable iff (!rst_n)
        pulse_closed |-> (phase_reg == PH_OPEN_LOOP && ticks_reg == '0))
        else $error("closed-loop pulse before open-loop time elapsed");

    // The calibration offset flag is only raised on leaving settle.
    a_offset_rise: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !offset_reg && offset_next) |=> (phase_reg == PH_CALIBRATE))
        else $error("offset calibration started outside calibrate phase");

endmodule

// ===== hdl/motor_startup_sequencer_core.sv =====
// Top level of the motor start-up sequencer: tick input register, phase state
// machine, status register and configuration registers.
// Each accepted tick is held in the tick input register, then moves into the status
// register, which offers it as a status transaction. One tick per cycle while the status
// channel takes each result; the phase machine steps as each registered tick moves on.
// Reset (rst_n, asynchronous, active low): power-on phase, counter and flags clear,
// durations return to 1000 ticks; both pipeline registers empty.
module motor_startup_sequencer_core
    import msseq_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    msseq_cfg_if.sink     cfg,
    msseq_tick_if.sink    tick,
    msseq_status_if.source status
);

    durations_t durations;
    tick_item_t item_reg;
    logic       item_valid_reg;
    result_t    result;
    result_t    res_reg;
    logic       res_valid_reg;
    logic       res_load;
    logic       advance;

    // Handshake: the status register frees when empty or taken, the input register
    // frees when empty or when its tick advances.
    assign res_load   = !res_valid_reg || status.ready;
    assign advance    = item_valid_reg && res_load;
    assign tick.ready = !item_valid_reg || res_load;

    msseq_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .durations (durations)
    );

    msseq_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (item_reg),
        .durations (durations),
        .result    (result)
    );

    // Valid bits of the two pipeline registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (tick.ready)
            begin
                item_valid_reg <= tick.valid;
            end
            if (res_load)
            begin
                res_valid_reg <= item_valid_reg;
            end
        end
    end

    // Payload of the two pipeline registers.
    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            item_reg <= '{start_request: tick.start_request,
                          current_at_target: tick.current_at_target,
                          force_fault: tick.force_fault};
        end
        if (advance)
        begin
            res_reg <= result;
        end
    end

    assign status.valid                 = res_valid_reg;
    assign status.phase                 = res_reg.phase;
    assign status.offset_calibration_on = res_reg.offset_calibration_on;
    assign status.calibration_done      = res_reg.calibration_done;
    assign status.begin_open_loop       = res_reg.begin_open_loop;
    assign status.begin_closed_loop     = res_reg.begin_closed_loop;

endmodule
